[src/flt_pkg.sv]
// ----------------------------------------------------------------------------
// flt_pkg: shared definitions for the fraction reduction core
// Operand width, the divider request and response bundles, and sign helpers.
// ----------------------------------------------------------------------------
package flt_pkg;

	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH);

	typedef struct packed {
		logic             start;
		logic [WIDTH-1:0] dvd;
		logic [WIDTH-1:0] dvs;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [WIDTH-1:0] quo;
		logic [WIDTH-1:0] rem;
	} div_rsp_t;

	// Magnitude of a two's-complement word; the most negative value maps to 2^(WIDTH-1).
	function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
		logic [WIDTH-1:0] m;
		m = v[WIDTH-1] ? (~v + 1'b1) : v;
		return m;
	endfunction

	function automatic logic [WIDTH-1:0] apply_sign(input logic [WIDTH-1:0] m,
		input logic neg);
		logic [WIDTH-1:0] r;
		r = neg ? (~m + 1'b1) : m;
		return r;
	endfunction

endpackage

[src/flt_if.sv]
// ----------------------------------------------------------------------------
// flt_if: word channels of the fraction reduction core
// Input channel carries a fraction, output channel carries the reduced one.
// ----------------------------------------------------------------------------
interface flt_in_if;
	logic                      valid;
	logic                      ready;
	logic [flt_pkg::WIDTH-1:0] num_in;
	logic [flt_pkg::WIDTH-1:0] den_in;

	modport source (output valid, output num_in, output den_in, input ready);
	modport sink (input valid, input num_in, input den_in, output ready);
endinterface

interface flt_out_if;
	logic                      valid;
	logic                      ready;
	logic                      ok;
	logic [flt_pkg::WIDTH-1:0] num_out;
	logic [flt_pkg::WIDTH-1:0] den_out;

	modport source (output valid, output ok, output num_out, output den_out, input ready);
	modport sink (input valid, input ok, input num_out, input den_out, output ready);
endinterface

[src/fraction_lowest_terms_core.sv]
// ----------------------------------------------------------------------------
// fraction_lowest_terms_core: reduces a signed fraction to lowest terms
// Euclid's algorithm on magnitudes with signs tracked as in a truncating
// remainder, then both terms are divided by the signed common divisor.
//
//   channel   direction   word contents
//   din       in          num_in, den_in
//   dout      out         ok, num_out, den_out
//
// One word at a time. Each Euclid step and the numerator quotient take one pass
// of the bit-serial divider; the denominator quotient starts on the cycle the
// numerator one ends. A zero denominator goes straight from idle to the output
// load state. Reset clears all control state. The result sits in an output
// register, so a stalled dout does not hold back the next din word until the
// following result is ready.
// ----------------------------------------------------------------------------
module fraction_lowest_terms_core (
	input  logic    clk,
	input  logic    arst_n,
	flt_in_if.sink  din,
	flt_out_if.source dout
);
	import flt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EUC   = 6'b000010,
		S_EWAIT = 6'b000100,
		S_QN    = 6'b001000,
		S_QD    = 6'b010000,
		S_PUT   = 6'b100000
	} state_t;

	state_t state_q;

	logic [WIDTH-1:0] xm_q, ym_q, nmag_q, dmag_q;
	logic             xn_q, yn_q, nneg_q, dneg_q;
	logic             res_ok_q;
	logic [WIDTH-1:0] res_num_q, res_den_q;
	logic             out_valid_q;
	logic             out_ok_q;
	logic [WIDTH-1:0] out_num_q, out_den_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic in_fire;
	logic out_load;

	assign din.ready = (state_q == S_IDLE);
	assign in_fire   = din.valid && din.ready;
	assign out_load  = (state_q == S_PUT) && (!out_valid_q || dout.ready);

	flt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		div_req.start = 1'b0;
		div_req.dvd   = xm_q;
		div_req.dvs   = ym_q;
		unique case (state_q)
			S_EUC: begin
				div_req.start = 1'b1;
				if (ym_q == '0) begin
					div_req.dvd = nmag_q;
					div_req.dvs = xm_q;
				end
			end
			S_QN: begin
				div_req.start = div_rsp.done;
				div_req.dvd   = dmag_q;
				div_req.dvs   = xm_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= (din.den_in == '0) ? S_PUT : S_EUC;
					end
				end
				S_EUC: begin
					state_q <= (ym_q == '0) ? S_QN : S_EWAIT;
				end
				S_EWAIT: begin
					if (div_rsp.done) begin
						state_q <= S_EUC;
					end
				end
				S_QN: begin
					if (div_rsp.done) begin
						state_q <= S_QD;
					end
				end
				S_QD: begin
					if (div_rsp.done) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			nneg_q    <= din.num_in[WIDTH-1];
			dneg_q    <= din.den_in[WIDTH-1];
			nmag_q    <= mag_of(din.num_in);
			dmag_q    <= mag_of(din.den_in);
			xm_q      <= mag_of(din.num_in);
			xn_q      <= din.num_in[WIDTH-1];
			ym_q      <= mag_of(din.den_in);
			yn_q      <= din.den_in[WIDTH-1];
			res_ok_q  <= 1'b0;
			res_num_q <= din.num_in;
			res_den_q <= din.den_in;
		end
		if ((state_q == S_EWAIT) && div_rsp.done) begin
			// The remainder keeps the dividend's sign unless it is zero.
			xm_q <= ym_q;
			xn_q <= yn_q;
			ym_q <= div_rsp.rem;
			yn_q <= xn_q && (div_rsp.rem != '0);
		end
		if ((state_q == S_QN) && div_rsp.done) begin
			res_num_q <= apply_sign(div_rsp.quo, nneg_q != xn_q);
		end
		if ((state_q == S_QD) && div_rsp.done) begin
			res_den_q <= apply_sign(div_rsp.quo, dneg_q != xn_q);
			res_ok_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q  <= res_ok_q;
			out_num_q <= res_num_q;
			out_den_q <= res_den_q;
		end
	end

	assign dout.valid   = out_valid_q;
	assign dout.ok      = out_ok_q;
	assign dout.num_out = out_num_q;
	assign dout.den_out = out_den_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while a division is running");

	a_zero_den_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && din.den_in == '0) |=> (state_q == S_PUT))
		else $error("zero denominator did not go straight to the output");

	a_gcd_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QN || state_q == S_QD) |-> (ym_q == '0 && xm_q != '0))
		else $error("quotient phase entered with an unfinished or zero divisor");

	a_out_from_put: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dout.valid) |-> $past(state_q == S_PUT))
		else $error("output word appeared outside the output load state");

endmodule

[src/flt_div.sv]
// ----------------------------------------------------------------------------
// flt_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module flt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  flt_pkg::div_req_t req,
	output flt_pkg::div_rsp_t rsp
);
	import flt_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;

	logic [WIDTH:0]   shifted;
	logic [WIDTH+1:0] diff;
	logic             fits;

	// The partial remainder stays below the divisor, so the shifted value is
	// below twice the divisor and one trial subtraction settles each bit.
	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = ~diff[WIDTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dvd;
			dvs_q <= req.dvs;
		end else if (busy_q) begin
			rem_q <= fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: regression for fraction_lowest_terms_core
// Sends signed fractions over the input channel and checks every reduced word
// against an in-bench Euclid predictor. The run covers directed corners,
// weighted random fractions, back-to-back traffic and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

	localparam int W            = flt_pkg::WIDTH;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int HOLD_CYCLES  = 6000;
	localparam int DRAIN_CYCLES = 100;

	localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] FIB_45  = 32'd1134903170;
	localparam logic [W-1:0] FIB_46  = 32'd1836311903;

	typedef struct {
		logic         ok;
		logic [W-1:0] num;
		logic [W-1:0] den;
		logic [W-1:0] src_num;
		logic [W-1:0] src_den;
	} fraction_t;

	logic clk;
	logic arst_n;

	flt_in_if  din_if ();
	flt_out_if dout_if ();

	fraction_lowest_terms_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	fraction_t   expected_fracs[$];
	fraction_t   front;
	int          err_count      = 0;
	int          sent_count     = 0;
	int          checked_count  = 0;
	int          zero_den_count = 0;
	int unsigned cycle_count    = 0;
	bit          idle_on        = 1'b1;
	bit          hold_active    = 1'b0;
	event        hold_off_start;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Euclid on magnitudes; the remainder keeps the dividend's sign, so the
	// divisor ends up with the sign of the last nonzero term.
	function automatic fraction_t reduce_fraction(input logic [W-1:0] num,
		input logic [W-1:0] den);
		fraction_t    res;
		logic         nneg, dneg, xn, yn, rn;
		logic [W-1:0] nmag, dmag, xm, ym, rm, q;
		res.src_num = num;
		res.src_den = den;
		if (den == '0) begin
			res.ok  = 1'b0;
			res.num = num;
			res.den = den;
			return res;
		end
		nneg = num[W-1];
		dneg = den[W-1];
		nmag = nneg ? ({W{1'b0}} - num) : num;
		dmag = dneg ? ({W{1'b0}} - den) : den;
		xm = nmag;
		xn = nneg;
		ym = dmag;
		yn = dneg;
		while (ym != '0) begin
			rm = xm % ym;
			rn = xn && (rm != '0);
			xm = ym;
			xn = yn;
			ym = rm;
			yn = rn;
		end
		res.ok  = 1'b1;
		q       = nmag / xm;
		res.num = (nneg != xn) ? ({W{1'b0}} - q) : q;
		q       = dmag / xm;
		res.den = (dneg != xn) ? ({W{1'b0}} - q) : q;
		return res;
	endfunction

	// Mostly no gap, some short ones and a rare long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [W-1:0] with_random_sign(input logic [W-1:0] m);
		return $urandom_range(0, 1) ? (~m + 1'b1) : m;
	endfunction

	// Anything in the legal range; the most negative value is never produced.
	function automatic logic [W-1:0] rand_operand();
		return with_random_sign(W'($urandom_range(0, 32'h7fffffff)));
	endfunction

	task automatic report_mismatch(input string what, input logic [W-1:0] got,
		input logic [W-1:0] want, input fraction_t src);
		$display("MISMATCH %s: got %0d want %0d for %0d/%0d at cycle %0d", what,
			$signed(got), $signed(want), $signed(src.src_num), $signed(src.src_den),
			cycle_count);
		err_count++;
	endtask

	task automatic send_fraction(input logic [W-1:0] num, input logic [W-1:0] den);
		fraction_t want;
		int        gap;
		want = reduce_fraction(num, den);
		@(negedge clk);
		din_if.valid  = 1'b1;
		din_if.num_in = num;
		din_if.den_in = den;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		expected_fracs.push_back(want);
		sent_count++;
		if (den == '0)
			zero_den_count++;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			din_if.valid  = 1'b0;
			din_if.num_in = $urandom;
			din_if.den_in = $urandom;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic test_directed_cases();
		send_fraction(32'd0, 32'd1);
		send_fraction(32'd0, -32'sd7);
		send_fraction(32'd0, MAX_POS);
		send_fraction(32'd5, 32'd0);
		send_fraction(32'd0, 32'd0);
		send_fraction(MAX_POS, 32'd0);
		send_fraction(~MAX_POS + 32'd1, 32'd0);
		send_fraction(32'd1, 32'd1);
		send_fraction(-32'sd1, -32'sd1);
		send_fraction(MAX_POS, MAX_POS);
		send_fraction(~MAX_POS + 32'd1, MAX_POS);
		send_fraction(MAX_POS, ~MAX_POS + 32'd1);
		send_fraction(MAX_POS, 32'd1);
		send_fraction(32'd1, MAX_POS);
		send_fraction(~MAX_POS + 32'd1, -32'sd1);
		send_fraction(MAX_POS, MAX_POS - 32'd1);
		send_fraction(32'd12, -32'sd18);
		send_fraction(-32'sd12, 32'd18);
		send_fraction(-32'sd12, -32'sd18);
		// Consecutive Fibonacci numbers give the longest Euclid chain.
		send_fraction(FIB_46, FIB_45);
		send_fraction(~FIB_46 + 32'd1, FIB_45);
		send_fraction(FIB_45, ~FIB_46 + 32'd1);
		send_fraction(32'h40000000, 32'hE0000000);
		send_fraction(32'h55555555, 32'h2AAAAAAA);
	endtask

	task automatic test_random_mix(input int count);
		logic [W-1:0] num, den, g;
		int           kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				num = rand_operand();
				den = rand_operand();
			end else if (kind < 65) begin
				// Shared factor so the reduction actually divides something.
				g   = W'($urandom_range(1, 65535));
				num = with_random_sign(g * W'($urandom_range(0, 32767)));
				den = with_random_sign(g * W'($urandom_range(1, 32767)));
			end else if (kind < 80) begin
				num = with_random_sign(W'($urandom_range(0, 100)));
				den = with_random_sign(W'($urandom_range(0, 100)));
			end else if (kind < 90) begin
				num = rand_operand();
				den = '0;
			end else begin
				g   = W'($urandom_range(1, 46340));
				num = with_random_sign(g * W'($urandom_range(0, 46340)));
				den = with_random_sign(g);
			end
			send_fraction(num, den);
		end
	endtask

	task automatic test_no_idle(input int count);
		idle_on = 1'b0;
		test_random_mix(count);
		idle_on = 1'b1;
	endtask

	// The receiver stops taking words long enough that the output register
	// fills and the input channel has to stall.
	task automatic test_output_hold_off();
		-> hold_off_start;
		idle_on = 1'b0;
		for (int i = 0; i < 6; i++)
			send_fraction(rand_operand(), rand_operand());
		idle_on = 1'b1;
	endtask

	initial begin
		int stall_left;
		stall_left    = 0;
		dout_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_active) begin
				dout_if.ready = 1'b0;
			end else if (stall_left > 0) begin
				dout_if.ready = 1'b0;
				stall_left--;
			end else begin
				stall_left    = idle_on ? pick_gap() : 0;
				dout_if.ready = (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	initial begin
		forever begin
			@(hold_off_start);
			hold_active = 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_active = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (expected_fracs.size() == 0) begin
				$display("MISMATCH unexpected word: ok %0d num %0d den %0d at cycle %0d",
					dout_if.ok, $signed(dout_if.num_out), $signed(dout_if.den_out),
					cycle_count);
				err_count++;
			end else begin
				front = expected_fracs.pop_front();
				checked_count++;
				if (dout_if.ok !== front.ok)
					report_mismatch("ok", W'(dout_if.ok), W'(front.ok), front);
				if (dout_if.num_out !== front.num)
					report_mismatch("num_out", dout_if.num_out, front.num, front);
				if (dout_if.den_out !== front.den)
					report_mismatch("den_out", dout_if.den_out, front.den, front);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
			expected_fracs.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		din_if.valid  = 1'b0;
		din_if.num_in = '0;
		din_if.den_in = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_mix(300);
		test_no_idle(60);
		test_output_hold_off();
		test_random_mix(40);

		@(negedge clk);
		din_if.valid = 1'b0;
		while (expected_fracs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Reduced %0d fractions (%0d with a zero denominator), %0d words checked.",
			sent_count, zero_den_count, checked_count);
		$display("Traffic ran with random gaps, back to back, and with one %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
